FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the SHA-1 digest block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/sha1md_pkg.sv
// ---------------------------------------------------------------------------
// sha1md_pkg
// Types and constants shared by the SHA-1 digest modules.
// ---------------------------------------------------------------------------
`default_nettype none

package sha1md_pkg;

    typedef logic [31:0] word_t;
    typedef logic [4:0][31:0] digest_t;

    // Write request into the block buffer, one byte at a time.
    typedef struct packed {
        logic       en;
        logic [5:0] addr;
        logic [7:0] data;
    } buf_wr_t;

    // Commands from the sequencer to the round engine.
    typedef struct packed {
        logic start;
        logic init;
    } core_cmd_t;

    // Status from the round engine back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    localparam word_t K_0 = 32'h5a827999;
    localparam word_t K_1 = 32'h6ed9eba1;
    localparam word_t K_2 = 32'h8f1bbcdc;
    localparam word_t K_3 = 32'hca62c1d6;

    localparam digest_t H_INIT = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                  32'hefcdab89, 32'h67452301};

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [7:0] PAD_ZERO = 8'h00;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [2:0] LAST_WORD_IDX = 3'd4;

endpackage

`default_nettype wire

FILE: design/sha1md_if.sv
// ---------------------------------------------------------------------------
// sha1md_if
// Valid/ready channels for message bytes and digest words.
// ---------------------------------------------------------------------------
`default_nettype none

interface sha1md_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_valid,
                    output end_of_message, input ready);
    modport sink (input valid, input data_byte, input byte_valid,
                  input end_of_message, output ready);
endinterface

interface sha1md_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

`default_nettype wire

FILE: design/sha1_message_digest.sv
// ---------------------------------------------------------------------------
// sha1_message_digest
// Streaming SHA-1 hasher: byte requests in, five digest words out.
// ---------------------------------------------------------------------------
// Message bytes are taken one request per cycle and written into a 64-byte
// buffer memory. Each full block then runs through the round engine (a
// start step, 80 rounds at one per cycle, a chaining update), during
// which no request is taken. An end mark writes the padding and the 64-bit
// length into the buffer one byte per cycle, runs one or two more blocks,
// then presents the five digest words one per cycle as the sink takes them;
// the next message is taken after the last word is delivered. A request with
// neither a byte nor an end mark is taken and has no effect.
`default_nettype none

`include "assert_macros.svh"

module sha1_message_digest (
    input wire logic clk,
    input wire logic rst_n,
    sha1md_msg_if.sink   message,
    sha1md_dig_if.source digest
);
    import sha1md_pkg::*;

    localparam logic [2:0] S_IN     = 3'd0;
    localparam logic [2:0] S_PAD    = 3'd1;
    localparam logic [2:0] S_CSTART = 3'd2;
    localparam logic [2:0] S_CWAIT  = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    localparam logic [1:0] P_MARK = 2'd0;
    localparam logic [1:0] P_ZERO = 2'd1;
    localparam logic [1:0] P_LEN  = 2'd2;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  ret_reg, ret_next;
    logic [1:0]  mode_reg, mode_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic [2:0]  idx_reg, idx_next;

    buf_wr_t    wr;
    core_cmd_t  cmd;
    core_stat_t stat;
    logic [3:0] rd_addr;
    word_t      rd_data;
    digest_t    hash;
    logic [2:0] len_sel;
    logic [7:0] pad_byte;
    logic       take_in;
    logic       take_out;

    sha1md_buffer u_buffer (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sha1md_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .digest  (hash)
    );

    assign take_in  = message.valid && message.ready;
    assign take_out = digest.valid && digest.ready;

    // Length bytes go out most significant first at offsets 56 to 63.
    assign len_sel = ~fill_reg[2:0];

    always_comb
    begin
        case (mode_reg)
            P_MARK:  pad_byte = PAD_MARK;
            P_LEN:   pad_byte = len_reg[{len_sel, 3'b000} +: 8];
            default: pad_byte = PAD_ZERO;
        endcase
    end

    // Message sequencer.
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        mode_next  = mode_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        wr         = '0;
        cmd        = '0;
        case (state_reg)
            S_IN:
            begin
                if (take_in)
                begin
                    mode_next = P_MARK;
                    if (message.byte_valid)
                    begin
                        wr.en     = 1'b1;
                        wr.addr   = fill_reg;
                        wr.data   = message.data_byte;
                        len_next  = len_reg + 64'd8;
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            ret_next   = message.end_of_message ? S_PAD : S_IN;
                            state_next = S_CSTART;
                        end
                        else if (message.end_of_message)
                        begin
                            state_next = S_PAD;
                        end
                    end
                    else if (message.end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                wr.en     = 1'b1;
                wr.addr   = fill_reg;
                wr.data   = pad_byte;
                fill_next = fill_reg + 6'd1;
                if (mode_reg != P_LEN)
                begin
                    mode_next = (fill_reg == 6'd55) ? P_LEN : P_ZERO;
                end
                if (fill_reg == 6'd63)
                begin
                    ret_next   = (mode_reg == P_LEN) ? S_OUT : S_PAD;
                    state_next = S_CSTART;
                end
            end
            S_CSTART:
            begin
                cmd.start  = 1'b1;
                state_next = S_CWAIT;
            end
            S_CWAIT:
            begin
                if (stat.done)
                begin
                    idx_next   = 3'd0;
                    state_next = ret_reg;
                end
            end
            S_OUT:
            begin
                if (take_out)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == LAST_WORD_IDX)
                    begin
                        cmd.init   = 1'b1;
                        fill_next  = 6'd0;
                        len_next   = 64'd0;
                        state_next = S_IN;
                    end
                end
            end
            default:
            begin
                state_next = S_IN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IN;
            ret_reg   <= S_IN;
            mode_reg  <= P_MARK;
            fill_reg  <= 6'd0;
            len_reg   <= 64'd0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            mode_reg  <= mode_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
        end
    end

    // Channel outputs.
    assign message.ready      = (state_reg == S_IN);
    assign digest.valid       = (state_reg == S_OUT);
    assign digest.digest_word = hash[idx_reg];
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == LAST_WORD_IDX);

    // Checks.
    `ASSERT_CLK(a_ready_core_idle, !message.ready || !stat.busy,
        "request taken while the round engine is busy")
    `ASSERT_CLK(a_out_in_excl, !(message.ready && digest.valid),
        "input ready while a digest word is pending")
    `ASSERT_NEXT(a_clear_after_digest, take_out && digest.last_word,
        state_reg == S_IN && fill_reg == 6'd0 && len_reg == 64'd0,
        "message state not cleared after the last digest word")

endmodule

`default_nettype wire

FILE: design/sha1md_buffer.sv
// ---------------------------------------------------------------------------
// sha1md_buffer
// 64-byte block buffer held as sixteen big-endian 32-bit words, with byte
// writes and a registered word read.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1md_buffer (
    input  wire logic              clk,
    input  wire sha1md_pkg::buf_wr_t wr,
    input  wire logic [3:0]        rd_addr,
    output logic [31:0]            rd_data
);
    import sha1md_pkg::*;

    word_t      mem [16];
    word_t      rd_data_reg;
    logic [1:0] lane;

    // Byte 0 of a word is its most significant byte.
    assign lane = ~wr.addr[1:0];

    // Byte-lane write.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[5:2]][{lane, 3'b000} +: 8] <= wr.data;
        end
    end

    // Registered word read.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: design/sha1md_core.sv
// ---------------------------------------------------------------------------
// sha1md_core
// SHA-1 round engine: one round per cycle over 80 rounds, a rolling
// 16-word schedule and the five chaining words.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1md_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sha1md_pkg::core_cmd_t cmd,
    output sha1md_pkg::core_stat_t     stat,
    output logic [3:0]                 rd_addr,
    input  wire logic [31:0]           rd_data,
    output sha1md_pkg::digest_t        digest
);
    import sha1md_pkg::*;

    localparam logic [1:0] C_IDLE  = 2'd0;
    localparam logic [1:0] C_ROUND = 2'd1;
    localparam logic [1:0] C_FINAL = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [6:0] round_reg, round_next;
    digest_t    hash_reg, hash_next;
    word_t      a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t      w_reg [16];
    word_t      mix, wt, f, k, tmp;

    // Schedule word: from the buffer for the first sixteen rounds.
    assign mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign wt  = (round_reg < 7'd16) ? rd_data : {mix[30:0], mix[31]};

    // Round function and constant by round group.
    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = K_0;
        end
        else if (round_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K_1;
        end
        else if (round_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = K_2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K_3;
        end
    end

    assign tmp = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + wt;

    // Buffer read address runs one word ahead of the round.
    assign rd_addr = (state_reg == C_ROUND) ? (round_reg[3:0] + 4'd1) : 4'd0;

    // Sequencing of rounds and the final chaining update.
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        hash_next  = hash_reg;
        case (state_reg)
            C_IDLE:
            begin
                round_next = 7'd0;
                if (cmd.start)
                begin
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                round_next = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = C_FINAL;
                end
            end
            C_FINAL:
            begin
                hash_next[0] = hash_reg[0] + a_reg;
                hash_next[1] = hash_reg[1] + b_reg;
                hash_next[2] = hash_reg[2] + c_reg;
                hash_next[3] = hash_reg[3] + d_reg;
                hash_next[4] = hash_reg[4] + e_reg;
                state_next   = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
        if (cmd.init)
        begin
            hash_next = H_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= 7'd0;
            hash_reg  <= H_INIT;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            hash_reg  <= hash_next;
        end
    end

    // Working variables and schedule window.
    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && cmd.start)
        begin
            a_reg <= hash_reg[0];
            b_reg <= hash_reg[1];
            c_reg <= hash_reg[2];
            d_reg <= hash_reg[3];
            e_reg <= hash_reg[4];
        end
        else if (state_reg == C_ROUND)
        begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= wt;
        end
    end

    assign stat.busy = (state_reg != C_IDLE);
    assign stat.done = (state_reg == C_FINAL);
    assign digest    = hash_reg;

endmodule

`default_nettype wire
